/* rtl/core/dcmc_pkg.sv */
// ----------------------------------------------------------------------------
// dcmc_pkg
// Shared types, constants and width helpers for the donor-cell convection
// pipeline.
// ----------------------------------------------------------------------------
package dcmc_pkg;

    // velocity format: signed, 8 integer bits, the rest fraction
    localparam int VELOCITY_WIDTH_DEF = 32;
    localparam int VELOCITY_INT_BITS  = 8;

    // register widths
    localparam int INV_WIDTH   = 32;
    localparam int BLEND_WIDTH = 17;
    localparam int OUT_WIDTH   = 48;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;

    // reset values
    localparam logic [INV_WIDTH-1:0]   INV_RESET   = 32'd65536;
    localparam logic [BLEND_WIDTH-1:0] BLEND_RESET = 17'd0;

    // saturation limits of the Q24.24 results
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 48'sh8000_0000_0000;

    // number of register stages, output register included
    localparam int NUM_STAGES = 7;

    // register map, word index
    typedef enum logic [1:0] {
        REG_INV_WIDTH    = 2'd0,
        REG_INV_HEIGHT   = 2'd1,
        REG_UPWIND_BLEND = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [INV_WIDTH-1:0]   inv_cell_width;
        logic [INV_WIDTH-1:0]   inv_cell_height;
        logic [BLEND_WIDTH-1:0] upwind_blend;
    } cfg_t;

    // per-stage load strobes
    typedef struct packed {
        logic sum;
        logic prod;
        logic face;
        logic diff;
        logic part;
        logic term;
        logic out;
    } stage_load_t;

    // face value: 65536*a*b + gamma*|a|*d, with a, b, d one bit wider than
    // a velocity
    function automatic int face_width(input int vw);
        return 2 * vw + 22;
    endfunction

    // final right shift: 2*frac + 10
    function automatic int final_shift(input int vw);
        return 2 * (vw - VELOCITY_INT_BITS) + 10;
    endfunction

endpackage

/* rtl/core/dcmc_if.sv */
// ----------------------------------------------------------------------------
// dcmc_if
// Stream interfaces: velocity stencil in, convective terms out.
// ----------------------------------------------------------------------------
interface dcmc_stencil_if #(
    parameter int VELOCITY_WIDTH = dcmc_pkg::VELOCITY_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [VELOCITY_WIDTH-1:0] u_center;
    logic signed [VELOCITY_WIDTH-1:0] u_east;
    logic signed [VELOCITY_WIDTH-1:0] u_west;
    logic signed [VELOCITY_WIDTH-1:0] u_north;
    logic signed [VELOCITY_WIDTH-1:0] u_south;
    logic signed [VELOCITY_WIDTH-1:0] u_northwest;
    logic signed [VELOCITY_WIDTH-1:0] v_center;
    logic signed [VELOCITY_WIDTH-1:0] v_west;
    logic signed [VELOCITY_WIDTH-1:0] v_east;
    logic signed [VELOCITY_WIDTH-1:0] v_north;
    logic signed [VELOCITY_WIDTH-1:0] v_south;
    logic signed [VELOCITY_WIDTH-1:0] v_southeast;

    modport source (
        output valid, u_center, u_east, u_west, u_north, u_south, u_northwest,
               v_center, v_west, v_east, v_north, v_south, v_southeast,
        input  ready
    );

    modport sink (
        input  valid, u_center, u_east, u_west, u_north, u_south, u_northwest,
               v_center, v_west, v_east, v_north, v_south, v_southeast,
        output ready
    );
endinterface

interface dcmc_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dcmc_pkg::OUT_WIDTH-1:0]  conv_x;
    logic signed [dcmc_pkg::OUT_WIDTH-1:0]  conv_y;

    modport source (
        output valid, conv_x, conv_y,
        input  ready
    );

    modport sink (
        input  valid, conv_x, conv_y,
        output ready
    );
endinterface

/* rtl/core/donor_cell_momentum_convection.sv */
// ----------------------------------------------------------------------------
// donor_cell_momentum_convection
// One beat per cycle unless result back-pressure fills the pipeline.
// Seven register stages (sums, products, blend, difference, chunked scale
// multiply, reassembly, shift and saturate) each with a valid bit; rst_n
// empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module donor_cell_momentum_convection #(
    parameter int VELOCITY_WIDTH = dcmc_pkg::VELOCITY_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dcmc_stencil_if.sink                         stencil,
    dcmc_result_if.source                        result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dcmc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [dcmc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [dcmc_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready
);

    localparam int NS = dcmc_pkg::NUM_STAGES;
    localparam int FW = dcmc_pkg::face_width(VELOCITY_WIDTH);

    dcmc_pkg::cfg_t        cfg;
    dcmc_pkg::stage_load_t load;
    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         valid_next;
    logic [NS-1:0]         stage_ready;
    logic signed [FW-1:0]  face_val [8];

    // configuration registers
    dcmc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage ready chain: a stage loads when empty or when it moves on
    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
    end

    assign load.sum  = stage_ready[0];
    assign load.prod = stage_ready[1];
    assign load.face = stage_ready[2];
    assign load.diff = stage_ready[3];
    assign load.part = stage_ready[4];
    assign load.term = stage_ready[5];
    assign load.out  = stage_ready[6];

    // valid bits travel with the data
    always_comb
    begin
        valid_next[0] = stage_ready[0] ? stencil.valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign stencil.ready = stage_ready[0];
    assign result.valid  = valid_reg[NS-1];

    // the eight faces: x and y momentum, out and in, per direction
    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_ax_out (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.u_center), .flux1(stencil.u_east),
        .carry0(stencil.u_center), .carry1(stencil.u_east),
        .face_val(face_val[0])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_ax_in (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.u_west), .flux1(stencil.u_center),
        .carry0(stencil.u_west), .carry1(stencil.u_center),
        .face_val(face_val[1])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_ay_out (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.v_center), .flux1(stencil.v_east),
        .carry0(stencil.u_center), .carry1(stencil.u_north),
        .face_val(face_val[2])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_ay_in (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.v_south), .flux1(stencil.v_southeast),
        .carry0(stencil.u_south), .carry1(stencil.u_center),
        .face_val(face_val[3])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_bx_out (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.u_center), .flux1(stencil.u_north),
        .carry0(stencil.v_center), .carry1(stencil.v_east),
        .face_val(face_val[4])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_bx_in (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.u_west), .flux1(stencil.u_northwest),
        .carry0(stencil.v_west), .carry1(stencil.v_center),
        .face_val(face_val[5])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_by_out (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.v_center), .flux1(stencil.v_north),
        .carry0(stencil.v_center), .carry1(stencil.v_north),
        .face_val(face_val[6])
    );

    dcmc_face #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_face_by_in (
        .clk(clk), .load(load), .blend(cfg.upwind_blend),
        .flux0(stencil.v_south), .flux1(stencil.v_center),
        .carry0(stencil.v_south), .carry1(stencil.v_center),
        .face_val(face_val[7])
    );

    // x momentum term
    dcmc_combine #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_combine_x (
        .clk        (clk),
        .load       (load),
        .face_x_out (face_val[0]),
        .face_x_in  (face_val[1]),
        .face_y_out (face_val[2]),
        .face_y_in  (face_val[3]),
        .inv_x      (cfg.inv_cell_width),
        .inv_y      (cfg.inv_cell_height),
        .conv       (result.conv_x)
    );

    // y momentum term
    dcmc_combine #(.VELOCITY_WIDTH(VELOCITY_WIDTH)) u_combine_y (
        .clk        (clk),
        .load       (load),
        .face_x_out (face_val[4]),
        .face_x_in  (face_val[5]),
        .face_y_out (face_val[6]),
        .face_y_in  (face_val[7]),
        .inv_x      (cfg.inv_cell_width),
        .inv_y      (cfg.inv_cell_height),
        .conv       (result.conv_y)
    );

`ifndef SYNTHESIS
    // full pipeline with a stalled output takes no new beat
    assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result.ready) |-> !stencil.ready)
        else $error("stencil accepted into a full, stalled pipeline");

    // an accepted beat occupies the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (stencil.valid && stencil.ready) |=> valid_reg[0])
        else $error("accepted stencil beat dropped");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !(|valid_reg[NS-2:0])) |=> !result.valid)
        else $error("result beat repeated");
`endif

endmodule

/* rtl/core/dcmc_apb_regs.sv */
// ----------------------------------------------------------------------------
// dcmc_apb_regs
// APB register file: reciprocal cell sizes and the donor-cell blend weight.
// ----------------------------------------------------------------------------
module dcmc_apb_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dcmc_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [dcmc_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [dcmc_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                   pready,
    output dcmc_pkg::cfg_t                         cfg
);

    logic [dcmc_pkg::INV_WIDTH-1:0]   inv_w_reg;
    logic [dcmc_pkg::INV_WIDTH-1:0]   inv_h_reg;
    logic [dcmc_pkg::BLEND_WIDTH-1:0] blend_reg;
    logic                             wr_en;
    dcmc_pkg::reg_index_t             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = dcmc_pkg::reg_index_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_w_reg <= dcmc_pkg::INV_RESET;
            inv_h_reg <= dcmc_pkg::INV_RESET;
            blend_reg <= dcmc_pkg::BLEND_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                dcmc_pkg::REG_INV_WIDTH:    inv_w_reg <= pwdata;
                dcmc_pkg::REG_INV_HEIGHT:   inv_h_reg <= pwdata;
                dcmc_pkg::REG_UPWIND_BLEND:
                    blend_reg <= pwdata[dcmc_pkg::BLEND_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            dcmc_pkg::REG_INV_WIDTH:    prdata = inv_w_reg;
            dcmc_pkg::REG_INV_HEIGHT:   prdata = inv_h_reg;
            dcmc_pkg::REG_UPWIND_BLEND:
                prdata = {{(dcmc_pkg::APB_DATA_WIDTH-dcmc_pkg::BLEND_WIDTH){1'b0}},
                          blend_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.inv_cell_width  = inv_w_reg;
    assign cfg.inv_cell_height = inv_h_reg;
    assign cfg.upwind_blend    = blend_reg;

endmodule

/* rtl/core/dcmc_face.sv */
// ----------------------------------------------------------------------------
// dcmc_face
// Donor-cell face value in three stages: sums, products, blend.
// F = 65536*a*b + gamma*|a|*d, a = p0+p1, b = c0+c1, d = c0-c1.
// ----------------------------------------------------------------------------
module dcmc_face #(
    parameter int VELOCITY_WIDTH = dcmc_pkg::VELOCITY_WIDTH_DEF
) (
    input  logic                                             clk,
    input  dcmc_pkg::stage_load_t                            load,
    input  logic signed [VELOCITY_WIDTH-1:0]                 flux0,
    input  logic signed [VELOCITY_WIDTH-1:0]                 flux1,
    input  logic signed [VELOCITY_WIDTH-1:0]                 carry0,
    input  logic signed [VELOCITY_WIDTH-1:0]                 carry1,
    input  logic [dcmc_pkg::BLEND_WIDTH-1:0]                 blend,
    output logic signed [dcmc_pkg::face_width(VELOCITY_WIDTH)-1:0] face_val
);

    localparam int SW = VELOCITY_WIDTH + 1;                  // sums
    localparam int PW = 2 * SW + 1;                          // products
    localparam int FW = dcmc_pkg::face_width(VELOCITY_WIDTH);
    localparam int UW = PW + dcmc_pkg::BLEND_WIDTH + 1;      // gamma product

    logic signed [SW-1:0]     a_next;
    logic signed [SW-1:0]     b_next;
    logic signed [SW-1:0]     d_next;
    logic [SW-1:0]            a_bits;
    logic [SW-1:0]            mag_next;
    logic signed [SW-1:0]     a_reg;
    logic signed [SW-1:0]     b_reg;
    logic signed [SW-1:0]     d_reg;
    logic [SW-1:0]            mag_reg;

    logic signed [2*SW-1:0]   ab_raw;
    logic signed [PW-1:0]     q_next;
    logic signed [PW-1:0]     ab_reg;
    logic signed [PW-1:0]     q_reg;

    logic signed [UW-1:0]     upw;
    logic signed [PW+15:0]    central;
    logic signed [FW-1:0]     face_next;
    logic signed [FW-1:0]     face_reg;

    // stage 1: exact sums, difference and flux magnitude
    assign a_next   = {flux0[VELOCITY_WIDTH-1], flux0} + {flux1[VELOCITY_WIDTH-1], flux1};
    assign b_next   = {carry0[VELOCITY_WIDTH-1], carry0} + {carry1[VELOCITY_WIDTH-1], carry1};
    assign d_next   = {carry0[VELOCITY_WIDTH-1], carry0} - {carry1[VELOCITY_WIDTH-1], carry1};
    assign a_bits   = a_next;
    assign mag_next = a_bits[SW-1] ? (~a_bits + SW'(1)) : a_bits;

    always_ff @(posedge clk)
    begin
        if (load.sum)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            d_reg   <= d_next;
            mag_reg <= mag_next;
        end
    end

    // stage 2: a*b and |a|*d
    assign ab_raw = a_reg * b_reg;
    assign q_next = $signed({1'b0, mag_reg}) * d_reg;

    always_ff @(posedge clk)
    begin
        if (load.prod)
        begin
            ab_reg <= {ab_raw[2*SW-1], ab_raw};
            q_reg  <= q_next;
        end
    end

    // stage 3: blend weight and central term
    assign upw       = q_reg * $signed({1'b0, blend});
    assign central   = {ab_reg, 16'b0};
    assign face_next = FW'(central) + FW'(upw);

    always_ff @(posedge clk)
    begin
        if (load.face)
        begin
            face_reg <= face_next;
        end
    end

    assign face_val = face_reg;

endmodule

/* rtl/core/dcmc_combine.sv */
// ----------------------------------------------------------------------------
// dcmc_combine
// One convective term: face differences scaled by the reciprocal cell sizes,
// summed, shifted to Q24.24 and saturated. Four stages.
// ----------------------------------------------------------------------------
module dcmc_combine #(
    parameter int VELOCITY_WIDTH = dcmc_pkg::VELOCITY_WIDTH_DEF
) (
    input  logic                                                   clk,
    input  dcmc_pkg::stage_load_t                                  load,
    input  logic signed [dcmc_pkg::face_width(VELOCITY_WIDTH)-1:0] face_x_out,
    input  logic signed [dcmc_pkg::face_width(VELOCITY_WIDTH)-1:0] face_x_in,
    input  logic signed [dcmc_pkg::face_width(VELOCITY_WIDTH)-1:0] face_y_out,
    input  logic signed [dcmc_pkg::face_width(VELOCITY_WIDTH)-1:0] face_y_in,
    input  logic [dcmc_pkg::INV_WIDTH-1:0]                         inv_x,
    input  logic [dcmc_pkg::INV_WIDTH-1:0]                         inv_y,
    output logic signed [dcmc_pkg::OUT_WIDTH-1:0]                  conv
);

    localparam int FW  = dcmc_pkg::face_width(VELOCITY_WIDTH);
    localparam int DW  = FW + 1;                  // face difference
    localparam int CW  = (DW + 2) / 3;            // chunk width
    localparam int HW  = DW - 2 * CW;             // signed top chunk
    localparam int IW  = dcmc_pkg::INV_WIDTH + 1; // signed reciprocal
    localparam int LW  = CW + 1 + IW;             // chunk product
    localparam int HPW = HW + IW;                 // top chunk product
    localparam int TW  = DW + IW;                 // scaled direction term
    localparam int SH  = dcmc_pkg::final_shift(VELOCITY_WIDTH);
    localparam int RW  = TW + 1 - SH;             // after the shift
    localparam int OW  = dcmc_pkg::OUT_WIDTH;

    logic signed [DW-1:0]  diff_reg [2];
    logic signed [LW-1:0]  part_lo_reg [2];
    logic signed [LW-1:0]  part_mid_reg [2];
    logic signed [HPW-1:0] part_hi_reg [2];
    logic signed [TW-1:0]  term_reg [2];
    logic [IW-1:0]         inv_ext [2];

    logic signed [TW:0]    total;
    logic [RW-1:0]         shifted;
    logic [RW-OW:0]        top_bits;
    logic signed [OW-1:0]  conv_next;
    logic signed [OW-1:0]  conv_reg;

    assign inv_ext[0] = {1'b0, inv_x};
    assign inv_ext[1] = {1'b0, inv_y};

    // stage 4: outgoing minus incoming face
    always_ff @(posedge clk)
    begin
        if (load.diff)
        begin
            diff_reg[0] <= {face_x_out[FW-1], face_x_out} - {face_x_in[FW-1], face_x_in};
            diff_reg[1] <= {face_y_out[FW-1], face_y_out} - {face_y_in[FW-1], face_y_in};
        end
    end

    // stages 5 and 6 per direction: chunked multiply, then reassembly
    for (genvar g = 0; g < 2; g++)
    begin : g_dir
        logic signed [LW-1:0]  lo_prod;
        logic signed [LW-1:0]  mid_prod;
        logic signed [HPW-1:0] hi_prod;
        logic signed [TW-1:0]  term_next;

        assign lo_prod  = $signed({1'b0, diff_reg[g][CW-1:0]}) * $signed(inv_ext[g]);
        assign mid_prod = $signed({1'b0, diff_reg[g][2*CW-1:CW]}) * $signed(inv_ext[g]);
        assign hi_prod  = $signed(diff_reg[g][DW-1:2*CW]) * $signed(inv_ext[g]);

        always_ff @(posedge clk)
        begin
            if (load.part)
            begin
                part_lo_reg[g]  <= lo_prod;
                part_mid_reg[g] <= mid_prod;
                part_hi_reg[g]  <= hi_prod;
            end
        end

        assign term_next = TW'(part_lo_reg[g])
                         + (TW'(part_mid_reg[g]) <<< CW)
                         + (TW'(part_hi_reg[g]) <<< (2 * CW));

        always_ff @(posedge clk)
        begin
            if (load.term)
            begin
                term_reg[g] <= term_next;
            end
        end
    end

    // stage 7: add directions, floor shift, saturate
    assign total    = (TW + 1)'(term_reg[0]) + (TW + 1)'(term_reg[1]);
    assign shifted  = total[TW:SH];
    assign top_bits = shifted[RW-1:OW-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
            conv_next = shifted[OW-1:0];
        else if (shifted[RW-1])
            conv_next = dcmc_pkg::OUT_MIN;
        else
            conv_next = dcmc_pkg::OUT_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (load.out)
        begin
            conv_reg <= conv_next;
        end
    end

    assign conv = conv_reg;

endmodule

/* verif/tb_donor_cell_momentum_convection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_donor_cell_momentum_convection
// Self-checking bench for the donor-cell convection pipeline. Stencil beats
// go in under random source gaps and sink stalls. A bit-exact predictor in
// the scoreboard works out both convective terms for every accepted stencil,
// and result beats are checked in order against it. The register set is
// reprogrammed between phases over its extremes, and each register write is read back.
// ----------------------------------------------------------------------------
module tb_donor_cell_momentum_convection;

    localparam int VEL_W           = dcmc_pkg::VELOCITY_WIDTH_DEF;
    localparam int FRAC_BITS       = VEL_W - dcmc_pkg::VELOCITY_INT_BITS;
    localparam int SCALE_SHIFT     = 2 * FRAC_BITS + 10;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int SETTLE_CYCLES   = dcmc_pkg::NUM_STAGES + 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [dcmc_pkg::APB_ADDR_WIDTH-1:0] UNMAPPED_ADDR = 4'hC;

    typedef logic signed [VEL_W-1:0] vel_t;
    // wide enough for every exact intermediate of the face sums
    typedef logic signed [159:0] acc_t;

    localparam vel_t VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam vel_t VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam vel_t VEL_ONE = 1 << FRAC_BITS;
    localparam acc_t SAT_HI  = dcmc_pkg::OUT_MAX;
    localparam acc_t SAT_LO  = dcmc_pkg::OUT_MIN;

    typedef struct {
        vel_t u_center;
        vel_t u_east;
        vel_t u_west;
        vel_t u_north;
        vel_t u_south;
        vel_t u_northwest;
        vel_t v_center;
        vel_t v_west;
        vel_t v_east;
        vel_t v_north;
        vel_t v_south;
        vel_t v_southeast;
    } stencil_t;

    typedef struct {
        logic signed [dcmc_pkg::OUT_WIDTH-1:0] conv_x;
        logic signed [dcmc_pkg::OUT_WIDTH-1:0] conv_y;
    } conv_t;

    // ------------------------------------------------------------------------
    // Scoreboard: convection predictor plus in-order store of pending terms
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        logic [dcmc_pkg::INV_WIDTH-1:0]   inv_w;
        logic [dcmc_pkg::INV_WIDTH-1:0]   inv_h;
        logic [dcmc_pkg::BLEND_WIDTH-1:0] blend;
        conv_t                            pending_q[$];
        int unsigned                      failures;

        function new();
            inv_w    = dcmc_pkg::INV_RESET;
            inv_h    = dcmc_pkg::INV_RESET;
            blend    = dcmc_pkg::BLEND_RESET;
            failures = 0;
        endfunction

        function void note_failure(string msg);
            if (failures < REPORT_LIMIT)
                $display("ERROR: %s", msg);
            failures++;
        endfunction

        function void set_register(dcmc_pkg::reg_index_t idx,
                                   logic [dcmc_pkg::APB_DATA_WIDTH-1:0] val);
            case (idx)
                dcmc_pkg::REG_INV_WIDTH:    inv_w = val[dcmc_pkg::INV_WIDTH-1:0];
                dcmc_pkg::REG_INV_HEIGHT:   inv_h = val[dcmc_pkg::INV_WIDTH-1:0];
                dcmc_pkg::REG_UPWIND_BLEND: blend = val[dcmc_pkg::BLEND_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // central part 65536*a*b plus upwind part gamma*|a|*d, all exact
        function acc_t face_value(longint flux, longint carried, longint diff);
            acc_t fa, cb, dd, mag, gam;
            fa  = flux;
            cb  = carried;
            dd  = diff;
            mag = (flux < 0) ? -flux : flux;
            gam = {{(160-dcmc_pkg::BLEND_WIDTH){1'b0}}, blend};
            return ((fa * cb) <<< 16) + (mag * dd * gam);
        endfunction

        // weight both directions, one floor shift to Q24.24, then saturate
        function logic signed [dcmc_pkg::OUT_WIDTH-1:0] scale_sat(acc_t xpart, acc_t ypart);
            acc_t wx, wy, total;
            wx    = {{(160-dcmc_pkg::INV_WIDTH){1'b0}}, inv_w};
            wy    = {{(160-dcmc_pkg::INV_WIDTH){1'b0}}, inv_h};
            total = (xpart * wx + ypart * wy) >>> SCALE_SHIFT;
            if (total > SAT_HI)
                return dcmc_pkg::OUT_MAX;
            if (total < SAT_LO)
                return dcmc_pkg::OUT_MIN;
            return total[dcmc_pkg::OUT_WIDTH-1:0];
        endfunction

        function void note_stencil(stencil_t s);
            longint uc, ue, uw, un, us, unw, vc, vw, ve, vn, vs, vse;
            acc_t   ax, ay, bx, by;
            conv_t  want;
            uc = s.u_center;  ue = s.u_east;    uw = s.u_west;
            un = s.u_north;   us = s.u_south;   unw = s.u_northwest;
            vc = s.v_center;  vw = s.v_west;    ve = s.v_east;
            vn = s.v_north;   vs = s.v_south;   vse = s.v_southeast;
            // d(uu)/dx and d(uv)/dy for the x equation
            ax = face_value(uc + ue, uc + ue, uc - ue) - face_value(uw + uc, uw + uc, uw - uc);
            ay = face_value(vc + ve, uc + un, uc - un) - face_value(vs + vse, us + uc, us - uc);
            // d(uv)/dx and d(vv)/dy for the y equation
            bx = face_value(uc + un, vc + ve, vc - ve) - face_value(uw + unw, vw + vc, vw - vc);
            by = face_value(vc + vn, vc + vn, vc - vn) - face_value(vs + vc, vs + vc, vs - vc);
            want.conv_x = scale_sat(ax, ay);
            want.conv_y = scale_sat(bx, by);
            pending_q.push_back(want);
        endfunction

        function void check_result(logic signed [dcmc_pkg::OUT_WIDTH-1:0] cx,
                                   logic signed [dcmc_pkg::OUT_WIDTH-1:0] cy);
            conv_t want;
            if (pending_q.size() == 0)
            begin
                note_failure($sformatf("result beat with nothing pending: conv_x %h conv_y %h",
                                       cx, cy));
                return;
            end
            want = pending_q.pop_front();
            if (cx !== want.conv_x)
                note_failure($sformatf("conv_x expected %h got %h", want.conv_x, cx));
            if (cy !== want.conv_y)
                note_failure($sformatf("conv_y expected %h got %h", want.conv_y, cy));
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [dcmc_pkg::APB_ADDR_WIDTH-1:0] paddr;
    logic [dcmc_pkg::APB_DATA_WIDTH-1:0] pwdata;
    logic [dcmc_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                pready;

    conv_scoreboard sb;
    int unsigned    send_idle_pct = 0;
    int unsigned    stall_pct     = 0;
    int unsigned    cycle_count   = 0;

    dcmc_stencil_if #(.VELOCITY_WIDTH(VEL_W)) stencil_ch ();
    dcmc_result_if                            result_ch ();

    donor_cell_momentum_convection #(
        .VELOCITY_WIDTH (VEL_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stencil (stencil_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_donor_cell_momentum_convection NOT OK");
            $finish;
        end
    end

    // sink side: random stalls
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: note accepted stencils, check result beats
    always @(posedge clk)
    begin : monitor
        stencil_t seen;
        if (rst_n && sb != null)
        begin
            if (stencil_ch.valid && stencil_ch.ready)
            begin
                seen.u_center    = stencil_ch.u_center;
                seen.u_east      = stencil_ch.u_east;
                seen.u_west      = stencil_ch.u_west;
                seen.u_north     = stencil_ch.u_north;
                seen.u_south     = stencil_ch.u_south;
                seen.u_northwest = stencil_ch.u_northwest;
                seen.v_center    = stencil_ch.v_center;
                seen.v_west      = stencil_ch.v_west;
                seen.v_east      = stencil_ch.v_east;
                seen.v_north     = stencil_ch.v_north;
                seen.v_south     = stencil_ch.v_south;
                seen.v_southeast = stencil_ch.v_southeast;
                sb.note_stencil(seen);
            end
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.conv_x, result_ch.conv_y);
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [dcmc_pkg::APB_ADDR_WIDTH-1:0] addr,
                             input logic [dcmc_pkg::APB_DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // write, read back, then update the predictor
    task automatic write_register(input dcmc_pkg::reg_index_t idx,
                                  input logic [dcmc_pkg::APB_DATA_WIDTH-1:0] val);
        logic [dcmc_pkg::APB_DATA_WIDTH-1:0] got;
        logic [dcmc_pkg::APB_DATA_WIDTH-1:0] want;
        apb_write({idx, 2'b00}, val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        want = (idx == dcmc_pkg::REG_UPWIND_BLEND) ?
               (val & ((1 << dcmc_pkg::BLEND_WIDTH) - 1)) : val;
        if (got !== want)
            sb.note_failure($sformatf("readback of %s expected %h got %h",
                                      idx.name(), want, got));
        sb.set_register(idx, val);
    endtask

    task automatic apply_setting(input int unsigned which);
        logic [dcmc_pkg::APB_DATA_WIDTH-1:0] w, h, g;
        case (which)
            0:
            begin
                w = dcmc_pkg::INV_RESET;
                h = dcmc_pkg::INV_RESET;
                g = dcmc_pkg::BLEND_RESET;
            end
            // largest reciprocals, blend past full upwind: saturation territory
            1:       begin w = 32'hFFFF_FFFF; h = 32'hFFFF_FFFF; g = 32'h1_FFFF;   end
            2:       begin w = 32'd65536;     h = 32'd65536;     g = 32'd65536;    end
            // zero width reciprocal drops the x direction
            3:       begin w = 32'd0;         h = 32'hFFFF_FFFF; g = 32'h1_FFFF;   end
            4:       begin w = 32'hFFFF_FFFF; h = 32'd0;         g = 32'd0;        end
            6:       begin w = 32'd1;         h = 32'd1;         g = 32'd32768;    end
            7:
            begin
                w = $urandom_range(1 << 18);
                h = $urandom_range(1 << 18);
                g = $urandom_range(65536);
            end
            8:       begin w = 32'd131072;    h = 32'd32768;     g = $urandom_range(65536, 131071); end
            default: begin w = $urandom();    h = $urandom();    g = $urandom_range(131071); end
        endcase
        write_register(dcmc_pkg::REG_INV_WIDTH, w);
        write_register(dcmc_pkg::REG_INV_HEIGHT, h);
        write_register(dcmc_pkg::REG_UPWIND_BLEND, g);
        // a write to an unmapped word must leave the registers alone
        if (which == 1)
            apb_write(UNMAPPED_ADDR, $urandom());
    endtask

    // ------------------------------------------------------------------------
    // Stencil source
    // ------------------------------------------------------------------------
    // called at a falling edge, returns at a falling edge after the beat
    task automatic push_stencil(input stencil_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stencil_ch.valid <= 1'b0;
            @(negedge clk);
        end
        stencil_ch.valid       <= 1'b1;
        stencil_ch.u_center    <= s.u_center;
        stencil_ch.u_east      <= s.u_east;
        stencil_ch.u_west      <= s.u_west;
        stencil_ch.u_north     <= s.u_north;
        stencil_ch.u_south     <= s.u_south;
        stencil_ch.u_northwest <= s.u_northwest;
        stencil_ch.v_center    <= s.v_center;
        stencil_ch.v_west      <= s.v_west;
        stencil_ch.v_east      <= s.v_east;
        stencil_ch.v_north     <= s.v_north;
        stencil_ch.v_south     <= s.v_south;
        stencil_ch.v_southeast <= s.v_southeast;
        @(posedge clk);
        while (!stencil_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid, wait for every pending term, let the pipe settle
    task automatic drain_pipe();
        stencil_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    function automatic stencil_t uniform_stencil(vel_t u, vel_t v);
        stencil_t s;
        s.u_center = u;  s.u_east = u;  s.u_west = u;
        s.u_north  = u;  s.u_south = u; s.u_northwest = u;
        s.v_center = v;  s.v_west = v;  s.v_east = v;
        s.v_north  = v;  s.v_south = v; s.v_southeast = v;
        return s;
    endfunction

    task automatic run_directed();
        stencil_t s;
        push_stencil(uniform_stencil('0, '0));
        push_stencil(uniform_stencil(VEL_MAX, VEL_MAX));
        push_stencil(uniform_stencil(VEL_MIN, VEL_MIN));
        push_stencil(uniform_stencil(VEL_MAX, VEL_MIN));
        // center against opposite-signed neighbors, both ways round
        s = uniform_stencil(VEL_MIN, VEL_MAX);
        s.u_center = VEL_MAX;
        s.v_center = VEL_MIN;
        push_stencil(s);
        s = uniform_stencil(VEL_MAX, VEL_MAX);
        s.u_center = VEL_MIN;
        s.v_center = VEL_MIN;
        push_stencil(s);
        push_stencil(uniform_stencil(-1, 1));
        // fluxes of both signs, and a zero one, across the faces
        s.u_center = VEL_ONE;      s.u_east  = -3 * VEL_ONE;  s.u_west = VEL_ONE / 2;
        s.u_north  = -VEL_ONE;     s.u_south = 2 * VEL_ONE;   s.u_northwest = -VEL_ONE / 4;
        s.v_center = -VEL_ONE;     s.v_west  = VEL_ONE;       s.v_east = 3 * VEL_ONE;
        s.v_north  = -2 * VEL_ONE; s.v_south = VEL_ONE / 2;   s.v_southeast = -3 * VEL_ONE;
        push_stencil(s);
        push_stencil(uniform_stencil(32'h5555_5555, 32'hAAAA_AAAA));
        s = uniform_stencil(32'hAAAA_AAAA, 32'h5555_5555);
        s.u_center = VEL_MAX;
        s.v_south  = VEL_MIN;
        push_stencil(s);
    endtask

    function automatic vel_t random_velocity(int unsigned style);
        case (style)
            0: return $urandom();
            // within +-1.0
            1: return vel_t'(int'($urandom_range(1 << (FRAC_BITS + 1))) - VEL_ONE);
            2:
            begin
                case ($urandom_range(4))
                    0:       return VEL_MAX;
                    1:       return VEL_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return $urandom();
                endcase
            end
            // within +-1/16
            default: return vel_t'(int'($urandom_range(1 << (FRAC_BITS - 3))) - (VEL_ONE >>> 4));
        endcase
    endfunction

    function automatic stencil_t random_stencil();
        stencil_t    s;
        int unsigned style;
        style = $urandom_range(3);
        s.u_center    = random_velocity(style);
        s.u_east      = random_velocity(style);
        s.u_west      = random_velocity(style);
        s.u_north     = random_velocity(style);
        s.u_south     = random_velocity(style);
        s.u_northwest = random_velocity(style);
        s.v_center    = random_velocity(style);
        s.v_west      = random_velocity(style);
        s.v_east      = random_velocity(style);
        s.v_north     = random_velocity(style);
        s.v_south     = random_velocity(style);
        s.v_southeast = random_velocity(style);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb                     = new();
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        result_ch.ready        = 1'b0;
        stencil_ch.valid       = 1'b0;
        stencil_ch.u_center    = '0;
        stencil_ch.u_east      = '0;
        stencil_ch.u_west      = '0;
        stencil_ch.u_north     = '0;
        stencil_ch.u_south     = '0;
        stencil_ch.u_northwest = '0;
        stencil_ch.v_center    = '0;
        stencil_ch.v_west      = '0;
        stencil_ch.v_east      = '0;
        stencil_ch.v_north     = '0;
        stencil_ch.v_south     = '0;
        stencil_ch.v_southeast = '0;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stencils at reset values, then at the extremes
        apply_setting(0);
        run_directed();
        drain_pipe();
        apply_setting(1);
        run_directed();
        drain_pipe();

        // random phases: each idling mode twice, a fresh register setting each
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 50; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 7;  stall_pct = 7;  end
            endcase
            apply_setting(p + 2);
            repeat (ITEMS_PER_PHASE)
                push_stencil(random_stencil());
            drain_pipe();
        end

        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("tb_donor_cell_momentum_convection OK");
        else
            $display("tb_donor_cell_momentum_convection NOT OK");
        $finish;
    end

endmodule
